FILE: rtl/tpdp_pkg.sv
package tpdp_pkg;

    localparam int LANES     = 4;
    localparam int ACT_W     = 8;
    localparam int CODE_W    = 2;
    localparam int CNT_W     = 3;
    localparam int SUM_W     = 32;
    // one lane term spans -128..+128
    localparam int TERM_W    = ACT_W + 1;
    // four terms add to at most +-512
    localparam int LSUM_W    = TERM_W + $clog2(LANES);
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = SUM_W;

    typedef logic [CODE_W-1:0]        t_code;
    typedef logic signed [ACT_W-1:0]  t_act;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [LSUM_W-1:0] t_lsum;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_code CODE_PLUS  = 2'b01;
    localparam t_code CODE_MINUS = 2'b10;

    typedef struct packed {
        logic valid;
        logic last;
    } t_item_ctl;

endpackage

FILE: rtl/tpdp_lane.sv
module tpdp_lane
    import tpdp_pkg::*;
(
    input  t_code i_code,
    input  t_act  i_act,
    input  logic  i_en,
    output t_term o_term
);

    t_term act_ext;

    assign act_ext = t_term'(i_act);

    always_comb begin
        o_term = '0;
        if (i_en) begin
            unique case (i_code)
                CODE_PLUS:  o_term = act_ext;
                CODE_MINUS: o_term = -act_ext;
                default:    o_term = '0;
            endcase
        end
    end

endmodule

FILE: rtl/tpdp_merge.sv
module tpdp_merge
    import tpdp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item_ctl         i_ctl,
    input  t_term [LANES-1:0] i_terms,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output t_sum              o_sum
);

    t_sum  r_acc;
    t_sum  r_out_data;
    t_sum  r_skid_data;
    logic  r_out_valid;
    logic  r_skid_valid;

    t_lsum lane_sum;
    t_sum  n_acc_sum;
    logic  accept;
    logic  push;
    logic  pop;

    always_comb begin
        lane_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            lane_sum = lane_sum + t_lsum'(i_terms[k]);
        end
    end

    assign n_acc_sum = r_acc + t_sum'(lane_sum);

    // skid slot full means two results are waiting
    assign o_ready = !r_skid_valid;
    assign accept  = i_ctl.valid && o_ready;
    assign push    = accept && i_ctl.last;
    assign pop     = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (accept) begin
            r_acc <= i_ctl.last ? '0 : n_acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || push;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_out_valid) begin
            r_out_data <= r_skid_valid ? r_skid_data : n_acc_sum;
        end else if (push) begin
            r_skid_data <= n_acc_sum;
        end
    end

    assign o_valid = r_out_valid;
    assign o_sum   = r_out_data;

endmodule

FILE: rtl/ternary_packed_dot_product.sv
// A sum ends at a tlast transfer and is registered to o_m_tvalid or into the skid slot.
// One transfer per cycle while skid is empty; four lanes and accumulate share one cycle.
// A two-deep output buffer keeps the input open while one result waits downstream.
// Reset (i_rst_n low at a clock edge) clears the accumulator and drops any pending result.
module ternary_packed_dot_product
    import tpdp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // weight_byte[7:0], act0[15:8], act1[23:16], act2[31:24], act3[39:32],
    // lanes_valid[42:40], zero fill[47:43]
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // dot_sum[31:0]
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    localparam int ACT_LSB = LANES * CODE_W;
    localparam int CNT_LSB = ACT_LSB + LANES * ACT_W;

    logic [LANES*CODE_W-1:0] weight_byte;
    logic [CNT_W-1:0]        lanes_valid;
    t_term [LANES-1:0]       terms;
    t_item_ctl               ctl;
    t_sum                    dot_sum;

    assign weight_byte = i_s_tdata[ACT_LSB-1:0];
    assign lanes_valid = i_s_tdata[CNT_LSB +: CNT_W];

    // counts above LANES enable every lane, which matches saturation
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        tpdp_lane u_lane (
            .i_code (t_code'(weight_byte[k*CODE_W +: CODE_W])),
            .i_act  (t_act'(i_s_tdata[ACT_LSB + k*ACT_W +: ACT_W])),
            .i_en   (lanes_valid > CNT_W'(k)),
            .o_term (terms[k])
        );
    end

    assign ctl.valid = i_s_tvalid;
    assign ctl.last  = i_s_tlast;

    tpdp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_terms (terms),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_sum   (dot_sum)
    );

    assign o_m_tdata = dot_sum;

endmodule

FILE: bench/tb.sv
module tb
    import tpdp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACT_LSB  = 8;
    localparam int CNT_LSB  = ACT_LSB + LANES * ACT_W;
    localparam int N_RANDOM = 1950;
    localparam int HOLD_AT  = 1000;
    localparam int HOLD_LEN = 300;

    typedef t_act [LANES-1:0] t_acts;

    typedef struct packed {
        logic [7:0]       wbyte;
        t_acts            act;
        logic [CNT_W-1:0] lanes;
        logic             last;
        logic             chk;   // sum below is typed in, not predicted
        t_sum             sum;
    } t_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tready = 1'b0;
    logic o_s_tready;
    logic o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;

    t_row plan[$];
    t_row row_q[$];      // one entry per transfer offered, popped on acceptance
    t_sum sum_q[$];      // expected dot sums, oldest first
    t_sum vec_sum = '0;  // running sum of the current vector
    int   n_acc = 0;
    int   n_fail = 0;
    bit   idle_on = 1'b1;
    bit   hold_done = 1'b0;

    ternary_packed_dot_product dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 clk = ~clk;

    function automatic t_sum accumulate_lanes(input t_sum acc, input logic [7:0] wbyte,
                                              input t_acts act, input logic [CNT_W-1:0] lanes);
        int    n;
        t_code code;
        n = (lanes > LANES) ? LANES : int'(lanes);
        for (int k = 0; k < n; k++) begin
            code = wbyte[2*k +: CODE_W];
            if (code == CODE_PLUS) begin
                acc = acc + t_sum'(act[k]);
            end else if (code == CODE_MINUS) begin
                acc = acc - t_sum'(act[k]);
            end
        end
        return acc;
    endfunction

    function automatic t_row row(input logic [7:0] wbyte, input int a0, input int a1,
                                 input int a2, input int a3, input int lanes,
                                 input bit last, input bit chk, input int sum);
        t_row r;
        r.wbyte  = wbyte;
        r.act[0] = t_act'(a0);
        r.act[1] = t_act'(a1);
        r.act[2] = t_act'(a2);
        r.act[3] = t_act'(a3);
        r.lanes  = lanes[CNT_W-1:0];
        r.last   = last;
        r.chk    = chk;
        r.sum    = t_sum'(sum);
        return r;
    endfunction

    task automatic send(input t_row r);
        row_q.push_back(r);
        while (idle_on && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({r.lanes, r.act, r.wbyte});
        s_tlast  <= r.last;
        do @(posedge clk); while (!o_s_tready);
        @(negedge clk);
    endtask

    function automatic t_act rand_act();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? t_act'(127) : t_act'(-128);
        end
        return t_act'($urandom);
    endfunction

    task automatic send_vector(input int len, input bit noisy);
        t_row r;
        for (int i = 0; i < len; i++) begin
            r.wbyte = 8'($urandom);
            for (int k = 0; k < LANES; k++) begin
                r.act[k] = rand_act();
            end
            r.last = (i == len - 1);
            if (noisy || $urandom_range(0, 15) == 0) begin
                r.lanes = CNT_W'($urandom_range(0, 7));
            end else if (r.last && $urandom_range(0, 2) == 0) begin
                r.lanes = CNT_W'($urandom_range(1, LANES));
            end else begin
                r.lanes = CNT_W'(LANES);
            end
            r.chk = 1'b0;
            r.sum = '0;
            send(r);
        end
    endtask

    // predictor and result check share one process so ordering within a step is fixed
    always @(posedge clk) begin : scoreboard
        t_row note;
        t_sum nxt;
        t_sum want;
        if (rst_n) begin
            if (s_tvalid && o_s_tready) begin
                note = row_q.pop_front();
                nxt = accumulate_lanes(vec_sum, s_tdata[7:0],
                                       s_tdata[ACT_LSB +: LANES*ACT_W],
                                       s_tdata[CNT_LSB +: CNT_W]);
                n_acc++;
                if (s_tlast) begin
                    sum_q.push_back(note.chk ? note.sum : nxt);
                    vec_sum = '0;
                end else begin
                    vec_sum = nxt;
                end
            end
            if (o_m_tvalid && m_tready) begin
                if (sum_q.size() == 0) begin
                    $error("dot_sum: no result expected, got %0d", $signed(o_m_tdata));
                    n_fail++;
                end else begin
                    want = sum_q.pop_front();
                    if (o_m_tdata !== want) begin
                        $error("dot_sum: expected %0d, got %0d", want, $signed(o_m_tdata));
                        n_fail++;
                    end
                end
            end
        end
    end

    // downstream side; one long hold-off lets the output buffer fill and back up the input
    initial begin : sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (!hold_done && n_acc >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (idle_on) begin
                m_tready <= ($urandom_range(0, 99) >= 33);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int n_items;
        int len;
        //                wbyte  act0  act1  act2  act3 lanes last chk   sum
        plan.push_back(row(8'h55,  127,  127,  127,  127, 4, 1, 1,  508));
        plan.push_back(row(8'hAA, -128, -128, -128, -128, 4, 1, 1,  512));
        plan.push_back(row(8'hAA,  127,  127,  127,  127, 4, 1, 1, -508));
        plan.push_back(row(8'h55, -128, -128, -128, -128, 4, 1, 1, -512));
        plan.push_back(row(8'h00,  127, -128,  127, -128, 4, 1, 1,    0));
        plan.push_back(row(8'hFF,  127, -128,  127, -128, 4, 1, 1,    0));
        // no lanes, with and without the end of the vector
        plan.push_back(row(8'h55,  100,  100,  100,  100, 0, 1, 1,    0));
        plan.push_back(row(8'h55,  100,  100,  100,  100, 0, 0, 0,    0));
        plan.push_back(row(8'h01,    5,    9,    9,    9, 1, 1, 1,    5));
        // lane counts above four clamp to four
        plan.push_back(row(8'h55,    1,    2,    3,    4, 7, 1, 1,   10));
        plan.push_back(row(8'h55,    1,    1,    1,    1, 5, 1, 1,    4));
        plan.push_back(row(8'hAA,    1,    1,    1,    1, 6, 1, 1,   -4));
        // short tail in the middle of a vector
        plan.push_back(row(8'h55,   10,   20,   30,   40, 2, 0, 0,    0));
        plan.push_back(row(8'h55,    1,    1,    1,    1, 4, 1, 1,   34));
        plan.push_back(row(8'h99,    1,    2,    3,    4, 4, 1, 1,   -2));
        plan.push_back(row(8'h40,    0,    0,    0, -128, 4, 1, 1, -128));
        plan.push_back(row(8'h80,    0,    0,    0, -128, 4, 1, 1,  128));
        plan.push_back(row(8'h55,  127,    0,    0,    0, 3, 1, 1,  127));
        plan.push_back(row(8'h36,   -7,   99, -128,   55, 3, 1, 0,    0));
        plan.push_back(row(8'hE4,   -1,   -2,   -3,   -4, 4, 0, 0,    0));
        plan.push_back(row(8'h1B,  127, -128,    0,    1, 3, 1, 0,    0));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i]) begin
            send(plan[i]);
        end

        n_items = 0;
        while (n_items < N_RANDOM) begin
            idle_on = !(n_items >= 1300 && n_items < 1650);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            send_vector(len, $urandom_range(0, 19) == 0);
            n_items += len;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sum_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_fail == 0 && sum_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
